### hdl/hcp_pkg.sv
// ----------------------------------------------------------------------------
// hcp_pkg
// Shared types, widths and register codes of the Hermite curve point block.
// ----------------------------------------------------------------------------
package hcp_pkg;

	// curve parameter: t = k / 2**STEPS_LOG2
	localparam int STEPS_LOG2 = 10;
	localparam int STEPS      = 1 << STEPS_LOG2;

	// number of pipeline register stages
	localparam int NSTAGE = 6;

	// field widths
	localparam int T_W   = 11;  // t_step
	localparam int K_W   = 11;  // clamped step, 0 .. STEPS
	localparam int PIX_W = 16;  // coordinates and registers

	// datapath widths, all signed
	localparam int A_W  = 19;           // 2p0 - 2p1 + r0 + r1
	localparam int B_W  = 20;           // -3p0 + 3p1 - 2r0 - r1
	localparam int X_W  = A_W + K_W + 1;  // a*k + b*S
	localparam int Y_W  = 42;           // x*k + r0*S^2
	localparam int YL_W = 21;           // low split of y
	localparam int YH_W = Y_W - YL_W;   // high split of y
	localparam int PL_W = YL_W + K_W;   // unsigned partial product
	localparam int PH_W = YH_W + K_W + 1; // signed partial product
	localparam int N_W  = 52;           // y*k + p0*S^3
	localparam int Q_W  = N_W - 3 * STEPS_LOG2; // integer part

	localparam logic [K_W-1:0] K_MAX = K_W'(STEPS);

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_X         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_Y         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TANGENT_START = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TANGENT_END   = 3'd5;

	// per-stage load enables, bit i loads stage i+1
	typedef struct packed {
		logic [NSTAGE-1:0] load;
	} hcp_ctrl_t;

endpackage

### hdl/hcp_if.sv
// ----------------------------------------------------------------------------
// hcp_step_if / hcp_point_if
// Valid/ready channels for curve steps in and curve points out.
// ----------------------------------------------------------------------------
interface hcp_step_if;
	logic                      valid;
	logic                      ready;
	logic [hcp_pkg::T_W-1:0]   t_step;

	modport source (output valid, output t_step, input ready);
	modport sink   (input valid, input t_step, output ready);
endinterface

interface hcp_point_if;
	logic                            valid;
	logic                            ready;
	logic signed [hcp_pkg::PIX_W-1:0] pixel_x;
	logic signed [hcp_pkg::PIX_W-1:0] pixel_y;
	logic                            clipped;

	modport source (output valid, output pixel_x, output pixel_y, output clipped,
		input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, input clipped,
		output ready);
endinterface

### hdl/hermite_curve_point.sv
// ----------------------------------------------------------------------------
// hermite_curve_point
// Cubic Hermite curve evaluator: one curve point per step, x and y in parallel.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  -------   ---  -------------  -------------------------------------------
//  step      in   valid/ready    t_step (11b unsigned, t = t_step / 1024)
//  point     out  valid/ready    pixel_x, pixel_y (16b signed), clipped
//  cfg       in   cfg_write      cfg_index (3b), cfg_data (16b)
//
//  six register stages, one transaction per clock unless the output stalls
//  the depth is set by the horner chain: coefficients, two multiplies by k,
//  a split wide multiply, the final sum and the truncate/saturate stage
//  stages load individually, so bubbles close up while the output is stalled
//  arst_n clears the valid bits and the configuration registers to zero
//
module hermite_curve_point (
	input  logic                              clk,
	input  logic                              arst_n,
	hcp_step_if.sink                          step,
	hcp_point_if.source                       point,
	input  logic                              cfg_write,
	input  logic [hcp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hcp_pkg::PIX_W-1:0]         cfg_data
);

	// configuration regs: user writes with no transaction in flight, unchecked
	logic signed [hcp_pkg::PIX_W-1:0] start_x_q;
	logic signed [hcp_pkg::PIX_W-1:0] start_y_q;
	logic signed [hcp_pkg::PIX_W-1:0] end_x_q;
	logic signed [hcp_pkg::PIX_W-1:0] end_y_q;
	logic signed [hcp_pkg::PIX_W-1:0] tangent_start_q;
	logic signed [hcp_pkg::PIX_W-1:0] tangent_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q       <= '0;
			start_y_q       <= '0;
			end_x_q         <= '0;
			end_y_q         <= '0;
			tangent_start_q <= '0;
			tangent_end_q   <= '0;
		end else if (cfg_write) begin
			// indexes past the last register are dropped
			unique case (cfg_index)
				hcp_pkg::REG_START_X:       start_x_q       <= cfg_data;
				hcp_pkg::REG_START_Y:       start_y_q       <= cfg_data;
				hcp_pkg::REG_END_X:         end_x_q         <= cfg_data;
				hcp_pkg::REG_END_Y:         end_y_q         <= cfg_data;
				hcp_pkg::REG_TANGENT_START: tangent_start_q <= cfg_data;
				hcp_pkg::REG_TANGENT_END:   tangent_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control and the clamped step travelling alongside the data
	hcp_pkg::hcp_ctrl_t        ctl;
	logic [hcp_pkg::K_W-1:0]   k_s1;
	logic [hcp_pkg::K_W-1:0]   k_s2;
	logic [hcp_pkg::K_W-1:0]   k_s3;

	hcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (step.valid),
		.t_step    (step.t_step),
		.out_ready (point.ready),
		.in_ready  (step.ready),
		.out_valid (point.valid),
		.ctl       (ctl),
		.k_s1      (k_s1),
		.k_s2      (k_s2),
		.k_s3      (k_s3)
	);

	// both axes share the tangents, only the end points differ
	logic clip_x;
	logic clip_y;

	hcp_axis u_axis_x (
		.clk   (clk),
		.ctl   (ctl),
		.p0    (start_x_q),
		.p1    (end_x_q),
		.r0    (tangent_start_q),
		.r1    (tangent_end_q),
		.k_s1  (k_s1),
		.k_s2  (k_s2),
		.k_s3  (k_s3),
		.pixel (point.pixel_x),
		.clip  (clip_x)
	);

	hcp_axis u_axis_y (
		.clk   (clk),
		.ctl   (ctl),
		.p0    (start_y_q),
		.p1    (end_y_q),
		.r0    (tangent_start_q),
		.r1    (tangent_end_q),
		.k_s1  (k_s1),
		.k_s2  (k_s2),
		.k_s3  (k_s3),
		.pixel (point.pixel_y),
		.clip  (clip_y)
	);

	// flag when either coordinate hit the rails
	assign point.clipped = clip_x || clip_y;

endmodule

### hdl/hcp_ctrl.sv
// ----------------------------------------------------------------------------
// hcp_ctrl
// Valid bits, per-stage load enables and the shared step pipeline.
// ----------------------------------------------------------------------------
module hcp_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [hcp_pkg::T_W-1:0]     t_step,
	input  logic                        out_ready,
	output logic                        in_ready,
	output logic                        out_valid,
	output hcp_pkg::hcp_ctrl_t          ctl,
	output logic [hcp_pkg::K_W-1:0]     k_s1,
	output logic [hcp_pkg::K_W-1:0]     k_s2,
	output logic [hcp_pkg::K_W-1:0]     k_s3
);

	logic [hcp_pkg::NSTAGE-1:0] vld_q;
	logic [hcp_pkg::NSTAGE-1:0] load;
	logic [hcp_pkg::K_W-1:0]    k_clamp;

	// a stage loads when empty or when its content moves on
	always_comb begin
		load[hcp_pkg::NSTAGE-1] = !vld_q[hcp_pkg::NSTAGE-1] || out_ready;
		for (int i = hcp_pkg::NSTAGE - 2; i >= 0; i--) begin
			load[i] = !vld_q[i] || load[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (load[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < hcp_pkg::NSTAGE; i++) begin
				if (load[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// steps beyond the end count as t = 1
	assign k_clamp = (t_step > hcp_pkg::T_W'(hcp_pkg::K_MAX)) ? hcp_pkg::K_MAX
		: hcp_pkg::K_W'(t_step);

	always_ff @(posedge clk) begin
		if (load[0]) begin
			k_s1 <= k_clamp;
		end
		if (load[1]) begin
			k_s2 <= k_s1;
		end
		if (load[2]) begin
			k_s3 <= k_s2;
		end
	end

	assign ctl.load  = load;
	assign in_ready  = load[0];
	assign out_valid = vld_q[hcp_pkg::NSTAGE-1];

endmodule

### hdl/hcp_axis.sv
// ----------------------------------------------------------------------------
// hcp_axis
// Six-stage Horner evaluation of one coordinate with truncation and saturation.
// ----------------------------------------------------------------------------
module hcp_axis (
	input  logic                               clk,
	input  hcp_pkg::hcp_ctrl_t                 ctl,
	input  logic signed [hcp_pkg::PIX_W-1:0]   p0,
	input  logic signed [hcp_pkg::PIX_W-1:0]   p1,
	input  logic signed [hcp_pkg::PIX_W-1:0]   r0,
	input  logic signed [hcp_pkg::PIX_W-1:0]   r1,
	input  logic [hcp_pkg::K_W-1:0]            k_s1,
	input  logic [hcp_pkg::K_W-1:0]            k_s2,
	input  logic [hcp_pkg::K_W-1:0]            k_s3,
	output logic signed [hcp_pkg::PIX_W-1:0]   pixel,
	output logic                               clip
);

	localparam int FRAC_W = 3 * hcp_pkg::STEPS_LOG2;

	logic signed [hcp_pkg::A_W-1:0]  a_s1;
	logic signed [hcp_pkg::B_W-1:0]  b_s1;
	logic signed [hcp_pkg::X_W-1:0]  x_s2;
	logic signed [hcp_pkg::Y_W-1:0]  y_s3;
	logic        [hcp_pkg::PL_W-1:0] pl_s4;
	logic signed [hcp_pkg::PH_W-1:0] ph_s4;
	logic signed [hcp_pkg::N_W-1:0]  n_s5;
	logic signed [hcp_pkg::PIX_W-1:0] pix_s6;
	logic                            clip_s6;

	// stage 1: polynomial coefficients
	logic signed [hcp_pkg::A_W-1:0] p0a, p1a, r0a, r1a, a_c;
	logic signed [hcp_pkg::B_W-1:0] p0b, p1b, r0b, r1b, b_c;

	always_comb begin
		p0a = hcp_pkg::A_W'(p0);
		p1a = hcp_pkg::A_W'(p1);
		r0a = hcp_pkg::A_W'(r0);
		r1a = hcp_pkg::A_W'(r1);
		a_c = (p0a <<< 1) - (p1a <<< 1) + r0a + r1a;
		p0b = hcp_pkg::B_W'(p0);
		p1b = hcp_pkg::B_W'(p1);
		r0b = hcp_pkg::B_W'(r0);
		r1b = hcp_pkg::B_W'(r1);
		b_c = (p1b <<< 1) + p1b - (p0b <<< 1) - p0b - (r0b <<< 1) - r1b;
	end

	// stage 2: x = a*k + b*S
	logic signed [hcp_pkg::A_W+hcp_pkg::K_W:0] ak;
	logic signed [hcp_pkg::X_W-1:0]            x_c;

	assign ak  = a_s1 * $signed({1'b0, k_s1});
	assign x_c = hcp_pkg::X_W'(ak) + (hcp_pkg::X_W'(b_s1) <<< hcp_pkg::STEPS_LOG2);

	// stage 3: y = x*k + r0*S^2
	logic signed [hcp_pkg::X_W+hcp_pkg::K_W:0] xk;
	logic signed [hcp_pkg::Y_W-1:0]            y_c;

	assign xk  = x_s2 * $signed({1'b0, k_s2});
	assign y_c = hcp_pkg::Y_W'(xk)
		+ (hcp_pkg::Y_W'(r0) <<< (2 * hcp_pkg::STEPS_LOG2));

	// stage 4: y*k split into two partial products
	logic        [hcp_pkg::PL_W-1:0] pl_c;
	logic signed [hcp_pkg::PH_W-1:0] ph_c;

	assign pl_c = y_s3[hcp_pkg::YL_W-1:0] * k_s3;
	assign ph_c = $signed(y_s3[hcp_pkg::Y_W-1:hcp_pkg::YL_W]) * $signed({1'b0, k_s3});

	// stage 5: numerator over S^3
	logic signed [hcp_pkg::N_W-1:0] n_c;

	assign n_c = (hcp_pkg::N_W'(ph_s4) <<< hcp_pkg::YL_W)
		+ hcp_pkg::N_W'($signed({1'b0, pl_s4}))
		+ (hcp_pkg::N_W'(p0) <<< FRAC_W);

	// stage 6: truncate toward zero, then saturate
	logic signed [hcp_pkg::Q_W-1:0]   q_c;
	logic signed [hcp_pkg::Q_W-1:0]   v_c;
	logic                             fix_c;
	logic [hcp_pkg::Q_W-hcp_pkg::PIX_W:0] hi_c;
	logic signed [hcp_pkg::PIX_W-1:0] pix_c;
	logic                             clip_c;

	always_comb begin
		q_c    = n_s5[hcp_pkg::N_W-1:FRAC_W];
		fix_c  = n_s5[hcp_pkg::N_W-1] && (|n_s5[FRAC_W-1:0]);
		v_c    = q_c + $signed({{(hcp_pkg::Q_W-1){1'b0}}, fix_c});
		hi_c   = v_c[hcp_pkg::Q_W-1:hcp_pkg::PIX_W-1];
		clip_c = !((&hi_c) || (~|hi_c));
		if (clip_c) begin
			pix_c = v_c[hcp_pkg::Q_W-1] ? {1'b1, {(hcp_pkg::PIX_W-1){1'b0}}}
				: {1'b0, {(hcp_pkg::PIX_W-1){1'b1}}};
		end else begin
			pix_c = v_c[hcp_pkg::PIX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			a_s1 <= a_c;
			b_s1 <= b_c;
		end
		if (ctl.load[1]) begin
			x_s2 <= x_c;
		end
		if (ctl.load[2]) begin
			y_s3 <= y_c;
		end
		if (ctl.load[3]) begin
			pl_s4 <= pl_c;
			ph_s4 <= ph_c;
		end
		if (ctl.load[4]) begin
			n_s5 <= n_c;
		end
		if (ctl.load[5]) begin
			pix_s6  <= pix_c;
			clip_s6 <= clip_c;
		end
	end

	assign pixel = pix_s6;
	assign clip  = clip_s6;

endmodule

### hdl/hcp_checker.sv
// ----------------------------------------------------------------------------
// hcp_checker
// Port-level checks of the Hermite curve point block, bound to the top level.
// ----------------------------------------------------------------------------
module hcp_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step_valid,
	input  logic                              step_ready,
	input  logic                              point_valid,
	input  logic                              point_ready,
	input  logic signed [hcp_pkg::PIX_W-1:0]  pixel_x,
	input  logic signed [hcp_pkg::PIX_W-1:0]  pixel_y,
	input  logic                              clipped
);

	localparam logic signed [hcp_pkg::PIX_W-1:0] PIX_MAX = {1'b0, {(hcp_pkg::PIX_W-1){1'b1}}};
	localparam logic signed [hcp_pkg::PIX_W-1:0] PIX_MIN = {1'b1, {(hcp_pkg::PIX_W-1){1'b0}}};

	// no result is offered once reset has been seen at a clock edge
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !point_valid)
		else $error("result offered during reset");

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_ready |=> point_valid
			&& $stable(pixel_x) && $stable(pixel_y) && $stable(clipped))
		else $error("stalled result changed");

	// a taken output frees the whole pipeline for a new transaction
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		point_ready |-> step_ready)
		else $error("input blocked although output is taken");

	// the clip flag only comes with a coordinate on a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && clipped |-> pixel_x == PIX_MAX || pixel_x == PIX_MIN
			|| pixel_y == PIX_MAX || pixel_y == PIX_MIN)
		else $error("clip flag without saturated coordinate");

	// step_valid is watched for completeness of the step channel
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!point_valid && !step_valid |=> !point_valid || $past(step_ready))
		else $error("result appeared without any pipeline activity");

endmodule

bind hermite_curve_point hcp_checker u_hcp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.step_valid  (step.valid),
	.step_ready  (step.ready),
	.point_valid (point.valid),
	.point_ready (point.ready),
	.pixel_x     (point.pixel_x),
	.pixel_y     (point.pixel_y),
	.clipped     (point.clipped)
);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Hermite curve point block: steps are sent on the
// step channel under random idling, each accepted step is evaluated by an exact
// integer curve evaluator and the points coming back are compared field by
// field, across reset, extreme and random curve settings.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// register indexes the block has no register behind, writes are dropped
	localparam logic [hcp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [hcp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam longint COORD_MAX = 2 ** (hcp_pkg::PIX_W - 1) - 1;
	localparam longint COORD_MIN = -(2 ** (hcp_pkg::PIX_W - 1));

	localparam int RAND_PHASES    = 10;
	localparam int RAND_PER_PHASE = 103;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic signed [hcp_pkg::PIX_W-1:0] x;
		logic signed [hcp_pkg::PIX_W-1:0] y;
		logic                             clipped;
	} curve_pt_t;

	logic clk;
	logic arst_n;
	logic                          cfg_write;
	logic [hcp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [hcp_pkg::PIX_W-1:0]     cfg_data;

	hcp_step_if  step_ch ();
	hcp_point_if point_ch ();

	hermite_curve_point i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step_ch),
		.point     (point_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// own copy of the curve registers, indexed like the block
	logic signed [hcp_pkg::PIX_W-1:0] curve_reg [6];

	logic [hcp_pkg::T_W-1:0] pending_steps [$];
	curve_pt_t               expected_points [$];

	int  mismatches;
	int  src_gap;
	int  sink_gap;
	int  src_idle_pct;
	int  sink_stall_pct;
	bit  quiet;

	// corners of the step field: ends of the curve, middle, one past the end
	// (clamped to t = 1) and the all-ones code
	logic [hcp_pkg::T_W-1:0] corner_steps [7] = '{11'd0, 11'd1, 11'd512, 11'd1023,
		11'd1024, 11'd1025, 11'h7ff};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// curve evaluator
	// ------------------------------------------------------------------------

	// one axis, exact: the point scaled by STEPS^3 is a cubic in k with integer
	// coefficients, so a single division truncates toward zero
	function automatic logic signed [hcp_pkg::PIX_W-1:0] axis_coord(longint p0,
		longint p1, longint r0, longint r1, longint k, inout bit sat);
		longint s;
		longint a;
		longint b;
		longint num;
		longint q;
		s   = longint'(hcp_pkg::STEPS);
		a   = 2 * p0 - 2 * p1 + r0 + r1;
		b   = -3 * p0 + 3 * p1 - 2 * r0 - r1;
		num = ((a * k + b * s) * k + r0 * s * s) * k + p0 * s * s * s;
		q   = num / (s * s * s);
		if (q > COORD_MAX) begin
			sat = 1'b1;
			q   = COORD_MAX;
		end else if (q < COORD_MIN) begin
			sat = 1'b1;
			q   = COORD_MIN;
		end
		return q[hcp_pkg::PIX_W-1:0];
	endfunction

	function automatic curve_pt_t curve_point(logic [hcp_pkg::T_W-1:0] t);
		curve_pt_t pt;
		bit        sat;
		longint    k;
		sat = 1'b0;
		// steps past the end of the curve sit on the end point
		k = (t > hcp_pkg::K_MAX) ? longint'(hcp_pkg::STEPS) : longint'(t);
		pt.x = axis_coord(curve_reg[hcp_pkg::REG_START_X], curve_reg[hcp_pkg::REG_END_X],
			curve_reg[hcp_pkg::REG_TANGENT_START], curve_reg[hcp_pkg::REG_TANGENT_END],
			k, sat);
		pt.y = axis_coord(curve_reg[hcp_pkg::REG_START_Y], curve_reg[hcp_pkg::REG_END_Y],
			curve_reg[hcp_pkg::REG_TANGENT_START], curve_reg[hcp_pkg::REG_TANGENT_END],
			k, sat);
		pt.clipped = sat;
		return pt;
	endfunction

	// ------------------------------------------------------------------------
	// step driver: one transaction per accepted step, idles in bursts
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			step_ch.valid  <= 1'b0;
			step_ch.t_step <= '0;
			src_gap = 0;
		end else begin
			// the registers only move while idle, so the point is fixed here
			if (step_ch.valid && step_ch.ready)
				expected_points.push_back(curve_point(step_ch.t_step));
			if (!step_ch.valid || step_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					step_ch.valid <= 1'b0;
				end else if (!quiet && pending_steps.size() > 0 &&
					$urandom_range(0, 99) < src_idle_pct) begin
					src_gap = $urandom_range(0, 11);
					step_ch.valid <= 1'b0;
				end else if (pending_steps.size() > 0) begin
					step_ch.valid  <= 1'b1;
					step_ch.t_step <= pending_steps.pop_front();
				end else begin
					step_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// point monitor: checks every transaction, stalls in bursts
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		curve_pt_t want;
		if (!arst_n) begin
			point_ch.ready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (point_ch.valid && point_ch.ready) begin
				if (expected_points.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: point with nothing outstanding: x %0d y %0d %s %0b",
							$realtime, point_ch.pixel_x, point_ch.pixel_y,
							"clipped", point_ch.clipped);
					mismatches++;
				end else begin
					want = expected_points.pop_front();
					if (point_ch.pixel_x !== want.x || point_ch.pixel_y !== want.y ||
						point_ch.clipped !== want.clipped) begin
						if (mismatches < MAX_REPORTS)
							$display({"%0t: point mismatch: exp x %0d y %0d clipped %0b,",
								" got x %0d y %0d clipped %0b"},
								$realtime, want.x, want.y, want.clipped,
								point_ch.pixel_x, point_ch.pixel_y, point_ch.clipped);
						mismatches++;
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				point_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
				sink_gap = $urandom_range(0, 11);
				point_ch.ready <= 1'b0;
			end else begin
				point_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	// one register write, the local copy follows at once since the block is idle
	task automatic write_reg(input logic [hcp_pkg::CFG_IDX_W-1:0] idx,
		input logic [hcp_pkg::PIX_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx <= hcp_pkg::REG_TANGENT_END)
			curve_reg[idx] = signed'(val);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic load_curve(input logic [hcp_pkg::PIX_W-1:0] sx,
		input logic [hcp_pkg::PIX_W-1:0] sy,
		input logic [hcp_pkg::PIX_W-1:0] ex, input logic [hcp_pkg::PIX_W-1:0] ey,
		input logic [hcp_pkg::PIX_W-1:0] ts, input logic [hcp_pkg::PIX_W-1:0] te);
		write_reg(hcp_pkg::REG_START_X, sx);
		write_reg(hcp_pkg::REG_START_Y, sy);
		write_reg(hcp_pkg::REG_END_X, ex);
		write_reg(hcp_pkg::REG_END_Y, ey);
		write_reg(hcp_pkg::REG_TANGENT_START, ts);
		write_reg(hcp_pkg::REG_TANGENT_END, te);
	endtask

	// block idle: nothing queued, nothing in flight, every point back
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_steps.size() != 0 || expected_points.size() != 0 || step_ch.valid);
	endtask

	// mix of full-range codes (lots of clipping), rails and modest curves
	function automatic logic [hcp_pkg::PIX_W-1:0] rand_reg_value();
		int v;
		v = int'($urandom_range(0, 4000)) - 2000;
		case ($urandom_range(0, 5)) inside
			0:       return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
			[1:2]:   return hcp_pkg::PIX_W'($urandom);
			default: return v[hcp_pkg::PIX_W-1:0];
		endcase
	endfunction

	// mostly on the curve, some past the end, now and then the exact ends
	function automatic logic [hcp_pkg::T_W-1:0] rand_step();
		case ($urandom_range(0, 9))
			0:       return hcp_pkg::T_W'($urandom_range(hcp_pkg::STEPS + 1,
				2 ** hcp_pkg::T_W - 1));
			1:       return ($urandom_range(0, 1) != 0) ? hcp_pkg::T_W'(hcp_pkg::STEPS)
				: '0;
			default: return hcp_pkg::T_W'($urandom_range(0, hcp_pkg::STEPS));
		endcase
	endfunction

	initial begin
		arst_n         = 1'b0;
		cfg_write      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		step_ch.valid  = 1'b0;
		step_ch.t_step = '0;
		point_ch.ready = 1'b0;
		quiet          = 1'b0;
		src_idle_pct   = 20;
		sink_stall_pct = 20;
		mismatches     = 0;
		foreach (curve_reg[i])
			curve_reg[i] = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// registers still at reset: every point sits at the origin
		pending_steps.push_back(corner_steps[0]);
		pending_steps.push_back(corner_steps[6]);
		wait_idle();

		// x and the tangents on the top rail, y on the bottom rail, x clips high and y clips low;
		// writes to the spare indexes must leave the curve alone
		load_curve(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
		write_reg(REG_SPARE_LO, 16'h8000);
		write_reg(REG_SPARE_HI, 16'h5a5a);
		foreach (corner_steps[i])
			pending_steps.push_back(corner_steps[i]);
		wait_idle();

		// bottom rail with opposing end points and tangents
		load_curve(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
		foreach (corner_steps[i])
			pending_steps.push_back(corner_steps[i]);
		wait_idle();

		// ordinary curve, negative values truncate toward zero
		load_curve(16'd100, 16'd200, 16'd900, -16'sd300, 16'd500, -16'sd700);
		foreach (corner_steps[i])
			pending_steps.push_back(corner_steps[i]);
		wait_idle();

		// random curves, each phase with its own idling mix, last one flat out
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			quiet          = (ph == RAND_PHASES - 1);
			src_idle_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
			sink_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
			for (int r = hcp_pkg::REG_START_X; r <= hcp_pkg::REG_TANGENT_END; r++)
				if ($urandom_range(0, 2) != 0)
					write_reg(hcp_pkg::CFG_IDX_W'(r), rand_reg_value());
			if ($urandom_range(0, 3) == 0)
				write_reg(hcp_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
					hcp_pkg::PIX_W'($urandom));
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				// hold the sender back once until the pipeline has fully drained
				if (ph == 2 && i == RAND_PER_PHASE / 2)
					wait_idle();
				pending_steps.push_back(rand_step());
			end
			wait_idle();
		end

		// allow any stray point to surface before the verdict
		repeat (2 * hcp_pkg::NSTAGE + 4) @(posedge clk);
		if (mismatches == 0 && expected_points.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

### files.f
hdl/hcp_pkg.sv
hdl/hcp_if.sv
hdl/hcp_ctrl.sv
hdl/hcp_axis.sv
hdl/hermite_curve_point.sv
hdl/hcp_checker.sv
tb/sv/tb_top.sv
